// ===== src/hist_pkg.sv =====
// Shared constants and codes of the histogram accumulator.
package hist_pkg;

    localparam int MAX_BINS = 1024;
    localparam int BIN_AW   = $clog2(MAX_BINS);

    localparam int SAMPLE_W = 16;
    localparam int WIDTH_W  = 17;
    localparam int NBINS_W  = 11;
    localparam int COUNT_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int VSUM_W   = 48;
    localparam int SQSUM_W  = 63;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] REG_LEFT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

endpackage

// ===== src/histogram_1d_accumulator.sv =====
// Top level of the one-dimensional histogram accumulator.
//
// Input channel: i_in_valid / o_in_stall carry one item (action, sample,
// bin_index). Output channel: o_out_valid / i_out_stall return one result
// per item with the touched bin, its count and the running totals.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data.
// The user must write them only while the block is idle; no logic checks this.
// Items are handled one at a time. An add that reaches the divider goes
// through the bit-serial divider that finds the bin, then, if the bin is in
// range, a read and a write back of the bin store, and then the load of the
// output register. An add with a negative offset or a zero bin width, an
// out-of-range read and an unused action go straight to the output register,
// a read in range reads the store first, and a clear first runs the sweep
// that writes zero into every entry of the store.
// After reset the same sweep runs with o_in_stall high.
// The result sits in an output register. While the receiver stalls, the
// block holds that result, may take and work one further item, and then
// waits with o_in_stall high until the held result has been delivered.
module histogram_1d_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [hist_pkg::WIDTH_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_action,
    input  logic signed [hist_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [9:0]                            i_bin_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [9:0]                            o_bin,
    output logic                                  o_out_of_range,
    output logic [hist_pkg::COUNT_W-1:0]          o_bin_count,
    output logic [hist_pkg::TOTAL_W-1:0]          o_events_in_range,
    output logic [hist_pkg::TOTAL_W-1:0]          o_events_lost,
    output logic signed [hist_pkg::VSUM_W-1:0]    o_value_sum,
    output logic [hist_pkg::SQSUM_W-1:0]          o_square_sum
);
    import hist_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_UPD, S_OUT, S_CLR} t_state;

    localparam logic [NBINS_W-1:0] MAX_NB = NBINS_W'(MAX_BINS);

    // Configuration.
    logic signed [SAMPLE_W-1:0] r_left;
    logic [WIDTH_W-1:0]         r_width;
    logic [NBINS_W-1:0]         r_nbins;

    // Control and item registers.
    t_state                     r_state;
    logic                       r_clr_reply;
    logic [BIN_AW-1:0]          r_clr_addr;
    logic [1:0]                 r_action;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [30:0]                r_sq;
    logic [BIN_AW-1:0]          r_bin;
    logic                       r_oor;
    logic [COUNT_W-1:0]         r_cnt;

    // Totals.
    logic [TOTAL_W-1:0]         r_in_tot;
    logic [TOTAL_W-1:0]         r_lost_tot;
    logic [VSUM_W-1:0]          r_vsum;
    logic [SQSUM_W-1:0]         r_sqsum;

    // Output register.
    logic                       r_out_valid;
    logic [BIN_AW-1:0]          r_o_bin;
    logic                       r_o_oor;
    logic [COUNT_W-1:0]         r_o_cnt;
    logic [TOTAL_W-1:0]         r_o_in;
    logic [TOTAL_W-1:0]         r_o_lost;
    logic [VSUM_W-1:0]          r_o_vsum;
    logic [SQSUM_W-1:0]         r_o_sqsum;

    // Bin store.
    logic [COUNT_W-1:0]         r_mem [MAX_BINS];
    logic [COUNT_W-1:0]         r_rd_data;
    logic                       mem_we;
    logic [BIN_AW-1:0]          mem_waddr;
    logic [COUNT_W-1:0]         mem_wdata;
    logic [BIN_AW-1:0]          mem_raddr;

    logic                       in_xfer;
    logic                       out_free;
    logic [NBINS_W-1:0]         nb;
    logic signed [SAMPLE_W:0]   diff;
    logic                       div_start;
    logic                       div_done;
    logic [SAMPLE_W-1:0]        quo;
    logic                       quo_hit;
    logic                       rd_hit;
    logic [COUNT_W-1:0]         cnt_inc;
    logic [SQSUM_W:0]           sq_add;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign nb       = (r_nbins > MAX_NB) ? MAX_NB : r_nbins;
    assign diff     = {i_sample[SAMPLE_W-1], i_sample} - {r_left[SAMPLE_W-1], r_left};
    assign div_start = in_xfer && (i_action == ACT_ADD) && !diff[SAMPLE_W]
                       && (r_width != '0);
    assign quo_hit  = {{(SAMPLE_W-NBINS_W){1'b0}}, nb} > quo;
    assign rd_hit   = {1'b0, i_bin_index} < nb;
    assign cnt_inc  = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;
    assign sq_add   = {1'b0, r_sqsum} + (SQSUM_W+1)'(r_sq);

    hist_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff[SAMPLE_W-1:0]),
        .i_divisor  (r_width),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        mem_raddr = (r_state == S_IDLE) ? i_bin_index : quo[BIN_AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_bin;
        mem_wdata = cnt_inc;
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_UPD && r_action == ACT_ADD) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_width <= WIDTH_W'(1);
            r_nbins <= NBINS_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEFT_LIMIT:  r_left  <= i_cfg_data[SAMPLE_W-1:0];
                REG_BIN_WIDTH:   r_width <= i_cfg_data;
                REG_BINS_IN_USE: r_nbins <= i_cfg_data[NBINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_reply <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_in_tot    <= '0;
            r_lost_tot  <= '0;
            r_vsum      <= '0;
            r_sqsum     <= '0;
        end else begin
            // The output state reloads the output register itself.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_action <= i_action;
                        r_sample <= i_sample;
                        r_sq     <= 31'(32'(i_sample) * 32'(i_sample));
                        r_bin    <= (i_action == ACT_READ && rd_hit) ? i_bin_index : '0;
                        r_oor    <= (i_action == ACT_ADD && !div_start)
                                    || (i_action == ACT_READ && !rd_hit);
                        r_cnt    <= '0;
                        case (i_action)
                            ACT_ADD: begin
                                if (div_start) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_state <= S_OUT;
                                    if (r_lost_tot != '1) begin
                                        r_lost_tot <= r_lost_tot + 1'b1;
                                    end
                                end
                            end
                            ACT_READ: begin
                                r_state <= rd_hit ? S_UPD : S_OUT;
                            end
                            ACT_CLEAR: begin
                                r_in_tot    <= '0;
                                r_lost_tot  <= '0;
                                r_vsum      <= '0;
                                r_sqsum     <= '0;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (quo_hit) begin
                            r_bin   <= quo[BIN_AW-1:0];
                            r_state <= S_UPD;
                        end else begin
                            r_oor   <= 1'b1;
                            r_state <= S_OUT;
                            if (r_lost_tot != '1) begin
                                r_lost_tot <= r_lost_tot + 1'b1;
                            end
                        end
                    end
                end
                S_UPD: begin
                    // Store data for r_bin arrived this cycle; an add writes it back.
                    if (r_action == ACT_ADD) begin
                        r_cnt  <= cnt_inc;
                        r_vsum <= r_vsum + VSUM_W'(r_sample);
                        r_sqsum <= sq_add[SQSUM_W] ? '1 : sq_add[SQSUM_W-1:0];
                        if (r_in_tot != '1) begin
                            r_in_tot <= r_in_tot + 1'b1;
                        end
                    end else begin
                        r_cnt <= r_rd_data;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_bin     <= r_bin;
                        r_o_oor     <= r_oor;
                        r_o_cnt     <= r_cnt;
                        r_o_in      <= r_in_tot;
                        r_o_lost    <= r_lost_tot;
                        r_o_vsum    <= r_vsum;
                        r_o_sqsum   <= r_sqsum;
                        r_state     <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == BIN_AW'(MAX_BINS - 1)) begin
                        r_bin   <= '0;
                        r_oor   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= r_clr_reply ? S_OUT : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_bin             = r_o_bin;
    assign o_out_of_range    = r_o_oor;
    assign o_bin_count       = r_o_cnt;
    assign o_events_in_range = r_o_in;
    assign o_events_lost     = r_o_lost;
    assign o_value_sum       = r_o_vsum;
    assign o_square_sum      = r_o_sqsum;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_bin == '0 && o_bin_count == '0))
        else $error("out-of-range result carries a bin or count");

    a_upd_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> ($past(r_state) == S_DIV || $past(r_state) == S_IDLE))
        else $error("store update without a preceding read");

    a_write_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_action == ACT_ADD) |=> (r_cnt != '0))
        else $error("bin count zero after an add");

endmodule

// ===== src/hist_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
module hist_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hist_pkg::SAMPLE_W-1:0]  i_dividend,
    input  logic [hist_pkg::WIDTH_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [hist_pkg::SAMPLE_W-1:0]  o_quotient
);
    import hist_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [WIDTH_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0] r_dq;
    logic [WIDTH_W-1:0]  r_dvs;

    logic [WIDTH_W-1:0]  n_trial;
    logic                n_qbit;

    always_comb begin
        n_trial = {r_rem[WIDTH_W-2:0], r_dq[SAMPLE_W-1]};
        n_qbit  = (n_trial >= r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dq   <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_qbit ? (n_trial - r_dvs) : n_trial;
                r_dq  <= {r_dq[SAMPLE_W-2:0], n_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SAMPLE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

// ===== sim/histogram_1d_accumulator_tb.sv =====
// Self-checking testbench of the histogram accumulator: directed cases, then random traffic.
module histogram_1d_accumulator_tb;
    import hist_pkg::*;

    typedef struct packed {
        logic [9:0]          bin;
        logic                oor;
        logic [COUNT_W-1:0]  count;
        logic [TOTAL_W-1:0]  in_range;
        logic [TOTAL_W-1:0]  lost;
        logic [VSUM_W-1:0]   vsum;
        logic [SQSUM_W-1:0]  sqsum;
    } t_hist_result;

    typedef struct {
        logic [1:0]   action;
        logic [15:0]  sample;
        logic [9:0]   bin_index;
        bit           typed;
        logic         oor;
        logic [15:0]  count;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [1:0]                  i_cfg_index = '0;
    logic [WIDTH_W-1:0]          i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_action = '0;
    logic signed [SAMPLE_W-1:0]  i_sample = '0;
    logic [9:0]                  i_bin_index = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [9:0]                  o_bin;
    logic                        o_out_of_range;
    logic [COUNT_W-1:0]          o_bin_count;
    logic [TOTAL_W-1:0]          o_events_in_range;
    logic [TOTAL_W-1:0]          o_events_lost;
    logic signed [VSUM_W-1:0]    o_value_sum;
    logic [SQSUM_W-1:0]          o_square_sum;

    histogram_1d_accumulator u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0]         counts [MAX_BINS];
    logic [TOTAL_W-1:0]  in_range_tot, lost_tot;
    logic [VSUM_W-1:0]   value_tot;
    logic [SQSUM_W-1:0]  square_tot;
    logic [15:0]         cfg_left;
    logic [16:0]         cfg_width;
    logic [10:0]         cfg_nbins;

    t_hist_result pending_results [$];
    t_hist_result typed_q [$];
    bit           typed_flag [$];

    int  errors = 0;
    int  results_seen = 0;
    int  adds_hit = 0;
    int  adds_lost = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    localparam int CYCLE_LIMIT = 10_000_000;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    function automatic void clear_histogram();
        foreach (counts[k]) counts[k] = '0;
        in_range_tot = '0;
        lost_tot = '0;
        value_tot = '0;
        square_tot = '0;
    endfunction

    function automatic t_hist_result bin_sample(input logic [1:0] action,
                                                input logic [15:0] sample,
                                                input logic [9:0] index);
        t_hist_result r;
        int           nb;
        int           diff;
        int unsigned  idx;
        logic [63:0]  sq;
        r = '0;
        nb = (cfg_nbins > MAX_BINS) ? MAX_BINS : cfg_nbins;
        if (action == ACT_ADD) begin
            diff = $signed(sample) - $signed(cfg_left);
            idx = 0;
            if (diff >= 0 && cfg_width != 0) idx = diff / cfg_width;
            if (diff >= 0 && cfg_width != 0 && idx < nb) begin
                sq = $signed(sample) * $signed(sample);
                if (counts[idx] != 16'hffff) counts[idx]++;
                if (in_range_tot != '1) in_range_tot++;
                value_tot = value_tot + {{32{sample[15]}}, sample};
                if ({1'b0, square_tot} + sq > 64'h7fff_ffff_ffff_ffff)
                    square_tot = '1;
                else
                    square_tot = square_tot + sq[62:0];
                r.bin = idx[9:0];
                r.count = counts[idx];
                adds_hit++;
            end else begin
                if (lost_tot != '1) lost_tot++;
                r.oor = 1'b1;
                adds_lost++;
            end
        end else if (action == ACT_READ) begin
            if (index < nb) begin
                r.bin = index;
                r.count = counts[index];
            end else begin
                r.oor = 1'b1;
            end
        end else if (action == ACT_CLEAR) begin
            clear_histogram();
        end
        r.in_range = in_range_tot;
        r.lost = lost_tot;
        r.vsum = value_tot;
        r.sqsum = square_tot;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] index, input logic [16:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == REG_LEFT_LIMIT) cfg_left = value[15:0];
        else if (index == REG_BIN_WIDTH) cfg_width = value;
        else if (index == REG_BINS_IN_USE) cfg_nbins = value[10:0];
    endtask

    // Drives one transfer; the predictor runs when it is accepted.
    // Valid stays high between items that follow with no idle cycle.
    task automatic send_item(input logic [1:0] action, input logic [15:0] sample,
                             input logic [9:0] index, input bit typed,
                             input logic oor, input logic [15:0] count);
        t_hist_result r;
        t_hist_result t;
        bit           idle;
        idle = !no_idle && ($urandom_range(99) < 34);
        if (idle) i_in_valid <= 1'b0;
        while (idle) begin
            @(posedge i_clk);
            idle = !no_idle && ($urandom_range(99) < 34);
        end
        i_in_valid <= 1'b1;
        i_action <= action;
        i_sample <= sample;
        i_bin_index <= index;
        do @(posedge i_clk); while (o_in_stall);
        r = bin_sample(action, sample, index);
        pending_results = {pending_results, r};
        t = '0;
        t.oor = oor;
        t.count = count;
        typed_q = {typed_q, t};
        typed_flag = {typed_flag, typed};
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_hist_result e;
        t_hist_result t;
        bit           tf;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("result with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                t = typed_q.pop_front();
                tf = typed_flag.pop_front();
                if (tf && (t.oor != o_out_of_range || t.count != o_bin_count)) begin
                    report_mismatch("table entry", 64'({o_out_of_range, o_bin_count}),
                                    64'({t.oor, t.count}));
                end
                if (o_bin != e.bin) report_mismatch("bin", 64'(o_bin), 64'(e.bin));
                if (o_out_of_range != e.oor)
                    report_mismatch("out_of_range", 64'(o_out_of_range), 64'(e.oor));
                if (o_bin_count != e.count)
                    report_mismatch("bin_count", 64'(o_bin_count), 64'(e.count));
                if (o_events_in_range != e.in_range)
                    report_mismatch("events_in_range", 64'(o_events_in_range),
                                    64'(e.in_range));
                if (o_events_lost != e.lost)
                    report_mismatch("events_lost", 64'(o_events_lost), 64'(e.lost));
                if (o_value_sum != e.vsum)
                    report_mismatch("value_sum", 64'($unsigned(o_value_sum)), 64'(e.vsum));
                if (o_square_sum != e.sqsum)
                    report_mismatch("square_sum", 64'(o_square_sum), 64'(e.sqsum));
            end
            results_seen++;
        end
        i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 34);
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    t_stim_row table_rows [$];

    function automatic t_stim_row row(input logic [1:0] a, input logic [15:0] s,
                                      input logic [9:0] b, input bit typed,
                                      input logic oor, input logic [15:0] c);
        t_stim_row x;
        x.action = a;
        x.sample = s;
        x.bin_index = b;
        x.typed = typed;
        x.oor = oor;
        x.count = c;
        return x;
    endfunction

    task automatic random_phase(input int n_items);
        logic [1:0]  a;
        logic [15:0] s;
        int          span;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k >= n_items / 2 && k < n_items / 2 + 60);
            case ($urandom_range(99)) inside
                [0:69]:  a = ACT_ADD;
                [70:96]: a = ACT_READ;
                98:      a = ACT_NONE;
                default: a = (k % 5 == 0) ? ACT_CLEAR : ACT_READ;
            endcase
            // Mostly samples that land near the covered span, some anywhere.
            span = cfg_width * ((cfg_nbins > MAX_BINS) ? MAX_BINS : cfg_nbins);
            if ($urandom_range(3) == 0 || span > 65536) s = 16'($urandom);
            else s = 16'(cfg_left + $urandom_range(span + 8) - 4);
            send_item(a, s, 10'($urandom), 1'b0, 1'b0, 16'h0);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        clear_histogram();
        cfg_left = 16'h0;
        cfg_width = 17'd1;
        cfg_nbins = 11'd1024;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: samples 0..1023 are bins, negatives are lost.
        table_rows = {table_rows, row(ACT_READ, 16'h0, 10'd0, 1'b1, 1'b0, 16'd0)};
        table_rows = {table_rows, row(ACT_READ, 16'h0, 10'd1023, 1'b1, 1'b0, 16'd0)};
        table_rows = {table_rows, row(ACT_ADD, 16'h0000, 10'd0, 1'b1, 1'b0, 16'd1)};
        table_rows = {table_rows, row(ACT_ADD, 16'h0000, 10'd0, 1'b1, 1'b0, 16'd2)};
        table_rows = {table_rows, row(ACT_ADD, 16'd1023, 10'd0, 1'b1, 1'b0, 16'd1)};
        table_rows = {table_rows, row(ACT_ADD, 16'd1024, 10'd0, 1'b1, 1'b1, 16'd0)};
        table_rows = {table_rows, row(ACT_ADD, 16'h8000, 10'd0, 1'b1, 1'b1, 16'd0)};
        table_rows = {table_rows, row(ACT_ADD, 16'h7fff, 10'd0, 1'b1, 1'b1, 16'd0)};
        table_rows = {table_rows, row(ACT_ADD, 16'hffff, 10'd0, 1'b1, 1'b1, 16'd0)};
        table_rows = {table_rows, row(ACT_READ, 16'h0, 10'd0, 1'b1, 1'b0, 16'd2)};
        table_rows = {table_rows, row(ACT_NONE, 16'hffff, 10'h3ff, 1'b1, 1'b0, 16'd0)};
        table_rows = {table_rows, row(ACT_CLEAR, 16'h0, 10'd0, 1'b1, 1'b0, 16'd0)};
        table_rows = {table_rows, row(ACT_READ, 16'h0, 10'd1023, 1'b1, 1'b0, 16'd0)};
        foreach (table_rows[k])
            send_item(table_rows[k].action, table_rows[k].sample, table_rows[k].bin_index,
                      table_rows[k].typed, table_rows[k].oor, table_rows[k].count);
        drain();

        // Extremes: most negative limit, widest bins, a single bin.
        write_reg(REG_LEFT_LIMIT, 17'h08000);
        write_reg(REG_BIN_WIDTH, 17'h10000);
        write_reg(REG_BINS_IN_USE, 17'd1);
        send_item(ACT_ADD, 16'h8000, 10'd0, 1'b1, 1'b0, 16'd1);
        send_item(ACT_ADD, 16'h7fff, 10'd0, 1'b0, 1'b0, 16'd0);
        send_item(ACT_READ, 16'h0, 10'd1, 1'b1, 1'b1, 16'd0);
        drain();
        // Largest limit, zero bins, an oversize bin count and a zero bin width.
        write_reg(REG_LEFT_LIMIT, 17'h07fff);
        write_reg(REG_BINS_IN_USE, 17'd0);
        send_item(ACT_ADD, 16'h7fff, 10'd0, 1'b1, 1'b1, 16'd0);
        send_item(ACT_READ, 16'h0, 10'd0, 1'b1, 1'b1, 16'd0);
        drain();
        write_reg(REG_BINS_IN_USE, 17'h7ff);
        write_reg(REG_BIN_WIDTH, 17'd0);
        send_item(ACT_ADD, 16'h7fff, 10'd0, 1'b1, 1'b1, 16'd0);
        drain();
        // Bin zero already holds the two samples taken with the widest bins.
        write_reg(REG_BIN_WIDTH, 17'd1);
        send_item(ACT_ADD, 16'h7fff, 10'd0, 1'b1, 1'b0, 16'd3);
        send_item(ACT_READ, 16'h0, 10'd1023, 1'b0, 1'b0, 16'd0);
        drain();

        // Several random settings, small bins used most.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_LEFT_LIMIT, (ph == 0) ? 17'h0 : 17'($urandom));
            write_reg(REG_BIN_WIDTH, (ph < 5) ? 17'($urandom_range(1, 64))
                                              : 17'($urandom_range(0, 65536)));
            write_reg(REG_BINS_IN_USE, (ph == 7) ? 17'd1024 : 17'($urandom_range(1, 64)));
            random_phase(135);
            drain();
        end

        $display("covered %0d results: %0d samples binned, %0d lost, over 8 random settings",
                 results_seen, adds_hit, adds_lost);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/hist_pkg.sv
src/hist_div.sv
src/histogram_1d_accumulator.sv
sim/histogram_1d_accumulator_tb.sv
